/* src/srle_pkg.sv */
package srle_pkg;

	localparam int MAX_ROW_DEFAULT   = 64;
	localparam int OUT_WORDS_DEFAULT = 8192;
	localparam int QUEUE_DEPTH       = 4;
	localparam int GROUP_WORDS       = 4;
	localparam int CFG_INDEX_W       = 1;
	localparam int CFG_DATA_W        = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH      = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 1'b1;

	localparam logic [6:0]  ROW_LENGTH_RESET = 7'd64;
	localparam logic [23:0] KEY_RESET        = 24'h808088;

	typedef struct packed {
		logic [23:0] pixel_rgb;
		logic        image_start;
	} in_t;

	typedef struct packed {
		logic [15:0] word;
		logic [12:0] word_index;
		logic        last;
	} out_t;

	// classified pixel handed from the input stage to the run tracker
	typedef struct packed {
		logic [15:0] pix_word;
		logic        transp;
		logic        start;
	} cls_t;

	// all words caused by one pixel
	typedef struct packed {
		out_t [GROUP_WORDS-1:0] w;
		logic [1:0]             cnt_m1;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* src/sprite_transparency_run_length_encoder_top.sv */
// Transparent run-length sprite encoder.
// Pixels enter on the in channel (in_valid / in_stall / in_data), one word per pixel,
// row by row; image_start marks the first pixel of an image and restarts the
// encoded buffer at index 0. Each pixel yields zero to four encoded words on
// the out channel (out_valid / out_stall / out_data), each carrying its buffer
// index; last marks the final word caused by a pixel.
// Throughput: one pixel per cycle enters as long as the four-entry word-group
// queue has room; the output register drains one word per cycle while out_stall
// is low, so the sustained pixel rate is set by the number of words per pixel.
// A pixel is registered in the input stage, the run tracker then pushes its word
// group into the queue, and the output register loads its first word from there.
// Stalling the out channel holds the current word; the queue then fills and
// in_stall rises once the input stage holds a pixel it cannot pass on.
// Reset clears all run state and returns row_length to 64 and the key to
// 0x808088. Registers are written through cfg_write / cfg_index / cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
module sprite_transparency_run_length_encoder_top #(
	parameter int MAX_ROW   = srle_pkg::MAX_ROW_DEFAULT,
	parameter int OUT_WORDS = srle_pkg::OUT_WORDS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  srle_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output srle_pkg::out_t                    out_data,
	input  logic                              cfg_write,
	input  logic [srle_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [srle_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import srle_pkg::*;

	logic [6:0]  row_length_q;
	logic [23:0] key_q;

	logic        cls_valid;
	cls_t        cls_data;
	logic        cls_take;
	q_stat_t     q_stat;
	logic        q_push;
	group_t      q_group;
	logic        q_pop;
	group_t      q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
			key_q        <= KEY_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_LENGTH:      row_length_q <= cfg_data[6:0];
				REG_TRANSPARENT_KEY: key_q        <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	srle_classify u_classify (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.transparent_key (key_q),
		.cls_valid       (cls_valid),
		.cls_data        (cls_data),
		.cls_take        (cls_take)
	);

	srle_runctl #(
		.MAX_ROW   (MAX_ROW),
		.OUT_WORDS (OUT_WORDS)
	) u_runctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls_valid  (cls_valid),
		.cls_data   (cls_data),
		.cls_take   (cls_take),
		.row_length (row_length_q),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_group    (q_group)
	);

	srle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_group (q_group),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	srle_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a word group never lands in a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("word group pushed into full queue");

	// nothing leaves an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// back pressure on the input only comes from a held pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (cls_valid && q_stat.full))
		else $error("input stalled without a blocked pixel");

	// a word taken with more to come leaves its group still held, so the queue is not empty
	a_group_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.last) |-> (!q_stat.empty))
		else $error("group split from its remaining words");

endmodule

/* src/srle_classify.sv */
module srle_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  srle_pkg::in_t      in_data,
	input  logic [23:0]        transparent_key,
	output logic               cls_valid,
	output srle_pkg::cls_t     cls_data,
	input  logic               cls_take
);
	import srle_pkg::*;

	localparam logic [23:0] SPECIAL [8] = '{
		24'h001C1C, 24'h003838, 24'h005555, 24'h007171,
		24'h008D8D, 24'h00AAAA, 24'h00C6C6, 24'h00E2E2
	};
	localparam logic [15:0] SPECIAL_BASE = 16'h8000;

	logic   valid_s1;
	cls_t   data_s1;
	cls_t   cls_next;
	logic   accept;

	always_comb begin
		logic [23:0] p;
		p = in_data.pixel_rgb;
		cls_next.pix_word = {1'b0, p[23:19], p[15:11], p[7:3]};
		// walk down so the lowest matching index wins
		for (int i = 7; i >= 0; i--) begin
			if (p == SPECIAL[i])
				cls_next.pix_word = SPECIAL_BASE | 16'(i);
		end
		cls_next.transp = (p == transparent_key);
		cls_next.start  = in_data.image_start;
	end

	assign in_stall  = valid_s1 & ~cls_take;
	assign accept    = in_valid & ~in_stall;
	assign cls_valid = valid_s1;
	assign cls_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~cls_take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= cls_next;
		end
	end

endmodule

/* src/srle_runctl.sv */
module srle_runctl #(
	parameter int MAX_ROW   = srle_pkg::MAX_ROW_DEFAULT,
	parameter int OUT_WORDS = srle_pkg::OUT_WORDS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cls_valid,
	input  srle_pkg::cls_t     cls_data,
	output logic               cls_take,
	input  logic [6:0]         row_length,
	input  srle_pkg::q_stat_t  q_stat,
	output logic               q_push,
	output srle_pkg::group_t   q_group
);
	import srle_pkg::*;

	localparam int          IW       = $clog2(OUT_WORDS);
	localparam logic [IW:0] OW       = (IW+1)'(OUT_WORDS);
	localparam logic [6:0]  MAX_ROW7 = 7'(MAX_ROW);

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] i, input logic [2:0] k);
		logic [IW:0] s;
		s = (IW+1)'(i) + (IW+1)'(k);
		if (s >= OW)
			s = s - OW;
		return s[IW-1:0];
	endfunction

	logic [6:0]    rowpos_q;
	logic          opq_q;
	logic [6:0]    runlen_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] wi_q;

	logic [6:0]    rowpos_n;
	logic          opq_n;
	logic [6:0]    runlen_n;
	logic [IW-1:0] slot_n;
	logic [IW-1:0] wi_n;
	logic [2:0]    nwords;
	group_t        grp;
	logic [6:0]    len;

	always_comb begin
		if (row_length == 7'd0)
			len = 7'd1;
		else if (row_length > MAX_ROW7)
			len = MAX_ROW7;
		else
			len = row_length;
	end

	always_comb begin
		logic [6:0]    rp;
		logic          opq;
		logic [6:0]    rl;
		logic [IW-1:0] slot;
		logic [IW-1:0] wi;
		logic [IW-1:0] idx [5];
		logic [2:0]    adv;
		logic [2:0]    n;

		// image start clears the run state before this pixel
		rp   = cls_data.start ? 7'd0 : rowpos_q;
		opq  = cls_data.start ? 1'b0 : opq_q;
		rl   = cls_data.start ? 7'd0 : runlen_q;
		slot = cls_data.start ? '0 : slot_q;
		wi   = cls_data.start ? '0 : wi_q;

		idx[0] = wi;
		for (int k = 1; k < 5; k++)
			idx[k] = wrap_add(wi, 3'(k));

		grp      = '0;
		n        = 3'd0;
		adv      = 3'd0;
		rowpos_n = rp + 7'd1;
		opq_n    = opq;
		runlen_n = rl;
		slot_n   = slot;

		if (cls_data.transp) begin
			if (opq) begin
				grp.w[0].word       = {9'd0, rl};
				grp.w[0].word_index = 13'(slot);
				n        = 3'd1;
				opq_n    = 1'b0;
				runlen_n = 7'd1;
			end else begin
				runlen_n = rl + 7'd1;
			end
		end else begin
			if (!opq) begin
				// skip word, then the length slot is held, then the pixel
				grp.w[0].word       = {9'd0, rl};
				grp.w[0].word_index = 13'(idx[0]);
				grp.w[1].word       = cls_data.pix_word;
				grp.w[1].word_index = 13'(idx[2]);
				slot_n   = idx[1];
				n        = 3'd2;
				adv      = 3'd3;
				opq_n    = 1'b1;
				runlen_n = 7'd1;
			end else begin
				grp.w[0].word       = cls_data.pix_word;
				grp.w[0].word_index = 13'(idx[0]);
				n        = 3'd1;
				adv      = 3'd1;
				runlen_n = rl + 7'd1;
			end
		end

		if (rowpos_n >= len) begin
			if (opq_n) begin
				grp.w[n[1:0]].word       = {9'd0, runlen_n};
				grp.w[n[1:0]].word_index = 13'(slot_n);
				n = n + 3'd1;
				grp.w[n[1:0]].word       = 16'd0;
				grp.w[n[1:0]].word_index = 13'(idx[adv]);
				n   = n + 3'd1;
				adv = adv + 3'd1;
			end else begin
				// only reached from a transparent pixel, nothing written at the write index yet
				grp.w[n[1:0]].word       = {9'd0, runlen_n};
				grp.w[n[1:0]].word_index = 13'(idx[0]);
				n = n + 3'd1;
				grp.w[n[1:0]].word       = 16'd0;
				grp.w[n[1:0]].word_index = 13'(idx[1]);
				n   = n + 3'd1;
				adv = 3'd2;
			end
			rowpos_n = 7'd0;
			opq_n    = 1'b0;
			runlen_n = 7'd0;
		end

		if (n != 3'd0)
			grp.w[2'(n - 3'd1)].last = 1'b1;
		grp.cnt_m1 = 2'(n - 3'd1);
		nwords     = n;
		wi_n       = idx[adv];
	end

	assign cls_take = cls_valid & ~q_stat.full;
	assign q_push   = cls_take & (nwords != 3'd0);
	assign q_group  = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowpos_q <= 7'd0;
			opq_q    <= 1'b0;
			runlen_q <= 7'd0;
			slot_q   <= '0;
			wi_q     <= '0;
		end else if (cls_take) begin
			rowpos_q <= rowpos_n;
			opq_q    <= opq_n;
			runlen_q <= runlen_n;
			slot_q   <= slot_n;
			wi_q     <= wi_n;
		end
	end

endmodule

/* src/srle_queue.sv */
module srle_queue #(
	parameter int DEPTH = srle_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  srle_pkg::group_t   push_group,
	input  logic               pop,
	output srle_pkg::group_t   head,
	output srle_pkg::q_stat_t  stat
);
	import srle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t        entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

endmodule

/* src/srle_emit.sv */
module srle_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  srle_pkg::group_t   head,
	input  srle_pkg::q_stat_t  q_stat,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output srle_pkg::out_t     out_data
);
	import srle_pkg::*;

	logic [1:0] sub_q;
	logic       out_valid_q;
	out_t       out_data_q;
	logic       load;

	// refill the output register from a non-empty queue whenever it is empty or being taken
	assign load  = ~q_stat.empty & (~out_valid_q | ~out_stall);
	assign q_pop = load & (sub_q == head.cnt_m1);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load | (out_valid_q & out_stall);
			if (load)
				sub_q <= q_pop ? 2'd0 : sub_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= head.w[sub_q];
		end
	end

endmodule
